[rtl/kcg_pkg.sv]
package kcg_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_ADVANCE = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CFG_ALPHA_LEN    = 3'd0,
    CFG_MIN_LEN      = 3'd1,
    CFG_MAX_LEN      = 3'd2,
    CFG_WORKER_COUNT = 3'd3,
    CFG_WORKER_ID    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [8:0] alphabet_len;
    logic [3:0] min_len;
    logic [3:0] max_len;
    logic [7:0] worker_count;
    logic [7:0] worker_id;
  } cfg_t;

  typedef struct packed {
    logic [63:0] candidate;
    logic [3:0]  cand_length;
    logic        owned;
    logic        exhausted;
  } res_t;

endpackage

[rtl/keyspace_candidate_generator.sv]
// brute-force candidate generator over a loadable alphabet
//
// s_* channel takes one request per cycle while s_tready is high: s_tuser selects load, advance,
// clear or no-op; a load writes one alphabet slot, an advance steps the
// position odometer and yields the next candidate, a clear empties it.
// every request gives exactly one result on the m_* channel: the shown
// candidate, its length, the owned flag and the exhausted flag.
// cfg_* writes the five control registers by index; write only when idle.
// throughput is one request per cycle while s_tready is high; the result is
// registered in the output buffer before m_tvalid. the rate rests on a
// combinational carry chain over the position row and on a read-ahead of
// the alphabet ram, which fetches the next character of the stepped position.
// reset empties all positions, restarts the rotation at one, clears the
// exhausted flag and loads register defaults; the alphabet is undefined
// until loaded and gets no clearing pass.
// when m_tready is low a two-entry output buffer keeps one more result and
// s_tready drops only when both entries are full.
module keyspace_candidate_generator #(
  parameter int MAX_POSITIONS  = 8,
  parameter int ALPHABET_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // alpha_index[7:0], alpha_char[15:8]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // candidate[63:0], cand_length[67:64], zero pad
  output logic [1:0]  m_tuser,   // owned[0], exhausted[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import kcg_pkg::*;

  localparam int AW = $clog2(ALPHABET_DEPTH);

  cfg_t          cfg;
  res_t          res;
  res_t          out_res;
  logic          accept;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alphabet_len <= 9'd1;
      cfg.min_len      <= 4'd1;
      cfg.max_len      <= 4'd8;
      cfg.worker_count <= 8'd1;
      cfg.worker_id    <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALPHA_LEN:    cfg.alphabet_len <= cfg_data;
        CFG_MIN_LEN:      cfg.min_len      <= cfg_data[3:0];
        CFG_MAX_LEN:      cfg.max_len      <= cfg_data[3:0];
        CFG_WORKER_COUNT: cfg.worker_count <= cfg_data[7:0];
        CFG_WORKER_ID:    cfg.worker_id    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign wr_en = accept && (func_t'(s_tuser) == FUNC_LOAD) &&
                 (9'(s_tdata[7:0]) < 9'(ALPHABET_DEPTH));

  kcg_amem #(
    .ALPHABET_DEPTH(ALPHABET_DEPTH)
  ) u_amem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(s_tdata[AW-1:0]),
    .wr_data(s_tdata[15:8]),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  kcg_odometer #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .ALPHABET_DEPTH(ALPHABET_DEPTH)
  ) u_odometer (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (func_t'(s_tuser)),
    .alpha_index(s_tdata[7:0]),
    .alpha_char (s_tdata[15:8]),
    .cfg        (cfg),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res        (res)
  );

  kcg_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_res   (res),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_res  (out_res),
    .out_ready(m_tready)
  );

  assign m_tdata = {4'b0000, out_res.cand_length, out_res.candidate};
  assign m_tuser = {out_res.exhausted, out_res.owned};

endmodule

[rtl/kcg_amem.sv]
module kcg_amem #(
  parameter int ALPHABET_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(ALPHABET_DEPTH)-1:0] wr_addr,
  input  logic [7:0]                        wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(ALPHABET_DEPTH)-1:0] rd_addr,
  output logic [7:0]                        rd_data
);

  logic [7:0] mem [ALPHABET_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/kcg_odometer.sv]
module kcg_odometer #(
  parameter int MAX_POSITIONS  = 8,
  parameter int ALPHABET_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  kcg_pkg::func_t                    func,
  input  logic [7:0]                        alpha_index,
  input  logic [7:0]                        alpha_char,
  input  kcg_pkg::cfg_t                     cfg,
  output logic                              rd_en,
  output logic [$clog2(ALPHABET_DEPTH)-1:0] rd_addr,
  input  logic [7:0]                        rd_data,
  output kcg_pkg::res_t                     res
);
  import kcg_pkg::*;

  localparam int AW = $clog2(ALPHABET_DEPTH);
  localparam int DW = $clog2(ALPHABET_DEPTH + 1);
  localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

  // digit 0 is empty, digit k shows alphabet entry k-1
  logic [DW-1:0] digit      [MAX_POSITIONS];
  logic [DW-1:0] digit_next [MAX_POSITIONS];
  // chr holds the shown character, nxt the character of the following digit
  logic [7:0]    chr        [MAX_POSITIONS];
  logic [7:0]    chr_next   [MAX_POSITIONS];
  logic [7:0]    nxt        [MAX_POSITIONS];
  logic [7:0]    nxt_next   [MAX_POSITIONS];
  logic [7:0]    nxt_eff    [MAX_POSITIONS];
  logic [7:0]    first_char;
  logic [7:0]    second_char;
  logic          pend_valid;
  logic          pend_valid_next;
  logic [PW-1:0] pend_pos;
  logic [PW-1:0] pend_pos_next;
  logic [7:0]    rot;
  logic [7:0]    rot_next;
  logic          done;
  logic          done_next;

  logic [3:0]    n_used;
  logic [8:0]    a_used;
  logic          load_ok;
  logic          is_adv;
  logic          is_clr;
  logic          found;
  logic [PW-1:0] p;
  logic [3:0]    len;
  logic [63:0]   cand;

  always_comb begin
    if (cfg.max_len == 4'd0) begin
      n_used = 4'd1;
    end else if (cfg.max_len > 4'(MAX_POSITIONS)) begin
      n_used = 4'(MAX_POSITIONS);
    end else begin
      n_used = cfg.max_len;
    end
    if (cfg.alphabet_len == 9'd0) begin
      a_used = 9'd1;
    end else if (cfg.alphabet_len > 9'(ALPHABET_DEPTH)) begin
      a_used = 9'(ALPHABET_DEPTH);
    end else begin
      a_used = cfg.alphabet_len;
    end
  end

  assign load_ok = accept && (func == FUNC_LOAD) && (9'(alpha_index) < 9'(ALPHABET_DEPTH));
  assign is_adv  = accept && (func == FUNC_ADVANCE) && !done;
  assign is_clr  = accept && (func == FUNC_CLEAR);

  // the ram read issued last cycle stands in for its position's next character
  always_comb begin
    for (int i = 0; i < MAX_POSITIONS; i++) begin
      nxt_eff[i] = nxt[i];
      if (pend_valid && (PW'(i) == pend_pos)) begin
        nxt_eff[i] = rd_data;
      end
    end
  end

  // rightmost used position that does not wrap takes the increment
  always_comb begin
    found = 1'b0;
    p     = '0;
    for (int i = 0; i < MAX_POSITIONS; i++) begin
      if (!found && (4'(i) < n_used) &&
          !((digit[i] != '0) && (9'(digit[i]) >= a_used))) begin
        found = 1'b1;
        p     = PW'(i);
      end
    end
  end

  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = '0;
    pend_pos_next = pend_pos;
    for (int i = 0; i < MAX_POSITIONS; i++) begin
      digit_next[i] = digit[i];
      chr_next[i]   = chr[i];
      nxt_next[i]   = nxt_eff[i];
      if (load_ok && (digit[i] != '0)) begin
        if (9'(digit[i]) == (9'(alpha_index) + 9'd1)) begin
          chr_next[i] = alpha_char;
        end
        if (9'(digit[i]) == 9'(alpha_index)) begin
          nxt_next[i] = alpha_char;
        end
      end
      if (is_clr) begin
        digit_next[i] = '0;
      end
      if (is_adv && (4'(i) < n_used)) begin
        if (!found || (PW'(i) < p) || (digit[i] == '0 && PW'(i) == p)) begin
          digit_next[i] = DW'(1);
          chr_next[i]   = first_char;
          nxt_next[i]   = second_char;
        end else if (PW'(i) == p) begin
          digit_next[i] = digit[i] + DW'(1);
          chr_next[i]   = nxt_eff[i];
          rd_en         = 1'b1;
          rd_addr       = digit_next[i][AW-1:0];
          pend_pos_next = PW'(i);
        end
      end
    end
    pend_valid_next = rd_en;
  end

  always_comb begin
    done_next = done;
    rot_next  = rot;
    if (is_clr) begin
      done_next = 1'b0;
      rot_next  = 8'd1;
    end else if (is_adv) begin
      if (!found) begin
        done_next = 1'b1;
      end else if (rot < cfg.worker_count) begin
        rot_next = 8'(rot + 8'd1);
      end else begin
        rot_next = 8'd1;
      end
    end
  end

  always_comb begin
    len  = 4'd0;
    cand = '0;
    for (int i = 0; i < MAX_POSITIONS; i++) begin
      if ((4'(i) < n_used) && (digit_next[i] != '0)) begin
        len          = len + 4'd1;
        cand[8*i +: 8] = chr_next[i];
      end
    end
  end

  always_comb begin
    res.candidate   = cand;
    res.cand_length = len;
    res.owned       = is_adv && found && (rot == cfg.worker_id) && (len >= cfg.min_len);
    res.exhausted   = done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_POSITIONS; i++) begin
        digit[i] <= '0;
      end
      pend_valid <= 1'b0;
      rot        <= 8'd1;
      done       <= 1'b0;
    end else begin
      for (int i = 0; i < MAX_POSITIONS; i++) begin
        digit[i] <= digit_next[i];
      end
      pend_valid <= pend_valid_next;
      rot        <= rot_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_POSITIONS; i++) begin
      chr[i] <= chr_next[i];
      nxt[i] <= nxt_next[i];
    end
    pend_pos <= pend_pos_next;
    if (load_ok && (alpha_index == 8'd0)) begin
      first_char <= alpha_char;
    end
    if (load_ok && (alpha_index == 8'd1)) begin
      second_char <= alpha_char;
    end
  end

  // a pending read always belongs to a position that was just stepped
  assert property (@(posedge clk) disable iff (rst) pend_valid |-> (digit[pend_pos] != '0))
    else $error("pending alphabet read for an empty position");

  assert property (@(posedge clk) disable iff (rst) is_clr |=> (rot == 8'd1) && !done)
    else $error("clear did not restart rotation and enumeration");

  assert property (@(posedge clk) disable iff (rst) (done && !is_clr) |=> done)
    else $error("exhausted flag dropped without clear");

  assert property (@(posedge clk) disable iff (rst) rot != 8'd0)
    else $error("rotation counter reached zero");

endmodule

[rtl/kcg_skid.sv]
module kcg_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  kcg_pkg::res_t in_res,
  output logic          in_ready,
  output logic          out_valid,
  output kcg_pkg::res_t out_res,
  input  logic          out_ready
);
  import kcg_pkg::*;

  logic skid_valid;
  logic skid_valid_next;
  logic out_valid_next;
  logic load_out;
  res_t skid_res;

  assign in_ready = !skid_valid;
  assign load_out = !out_valid || out_ready;

  always_comb begin
    out_valid_next  = load_out ? (skid_valid || in_valid) : 1'b1;
    skid_valid_next = skid_valid ? !load_out : (in_valid && !load_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res <= skid_valid ? skid_res : in_res;
    end
    if (!skid_valid && in_valid && !load_out) begin
      skid_res <= in_res;
    end
  end

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry held while output register is empty");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && in_valid) |=> (out_valid && skid_valid))
    else $error("request lost while output stalled");

  assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid entry not moved to output");

endmodule

[sim/testbench.sv]
import kcg_pkg::*;

// mirrors the odometer, alphabet and rotation, and queues the expected result per request
class keyspace_tracker;
  bit [7:0] alpha_mem [256];
  bit [8:0] digit [8];
  bit [7:0] rotation;
  bit       exhausted_flag;
  bit [8:0] alen_reg;
  bit [3:0] minl_reg;
  bit [3:0] maxl_reg;
  bit [7:0] wcount_reg;
  bit [7:0] wid_reg;
  res_t     expected_results [$];
  int       failures;

  function new();
    alen_reg = 9'd1;
    minl_reg = 4'd1;
    maxl_reg = 4'd8;
    wcount_reg = 8'd1;
    wid_reg = 8'd1;
    rotation = 8'd1;
    exhausted_flag = 1'b0;
    failures = 0;
    foreach (digit[i]) digit[i] = '0;
  endfunction

  function int unsigned positions_in_use();
    if (maxl_reg == 0) return 1;
    if (maxl_reg > 8) return 8;
    return 32'(maxl_reg);
  endfunction

  function int unsigned alphabet_in_use();
    if (alen_reg == 0) return 1;
    if (alen_reg > 256) return 256;
    return 32'(alen_reg);
  endfunction

  function void write_register(cfg_idx_t idx, bit [8:0] val);
    case (idx)
      CFG_ALPHA_LEN:    alen_reg = val;
      CFG_MIN_LEN:      minl_reg = val[3:0];
      CFG_MAX_LEN:      maxl_reg = val[3:0];
      CFG_WORKER_COUNT: wcount_reg = val[7:0];
      CFG_WORKER_ID:    wid_reg = val[7:0];
      default: ;
    endcase
  endfunction

  // characters of the nonempty positions, rightmost position in byte 0
  function void current_view(output bit [63:0] cand, output bit [3:0] len);
    cand = '0;
    len = '0;
    for (int i = 0; i < positions_in_use(); i++) begin
      if (digit[i] != 0) begin
        cand[8*i +: 8] = alpha_mem[digit[i] - 9'd1];
        len++;
      end
    end
  endfunction

  // returns 1 when a new candidate comes out
  function bit advance_odometer();
    int unsigned n;
    int unsigned a;
    n = positions_in_use();
    a = alphabet_in_use();
    if (exhausted_flag) return 1'b0;
    for (int p = 0; p < n; p++) begin
      if (digit[p] == 0) begin
        digit[p] = 9'd1;
        return 1'b1;
      end
      // a stale index past the alphabet wraps like the last entry
      if (digit[p] < a) begin
        digit[p] = digit[p] + 9'd1;
        return 1'b1;
      end
      digit[p] = 9'd1;
    end
    exhausted_flag = 1'b1;
    return 1'b0;
  endfunction

  function void note_request(func_t f, bit [7:0] idx, bit [7:0] chr);
    res_t      r;
    bit [63:0] cand;
    bit [3:0]  len;
    r.owned = 1'b0;
    case (f)
      FUNC_LOAD: alpha_mem[idx] = chr;
      FUNC_ADVANCE: begin
        if (advance_odometer()) begin
          current_view(cand, len);
          if (rotation == wid_reg && len >= minl_reg) r.owned = 1'b1;
          if (rotation < wcount_reg) rotation = rotation + 8'd1;
          else rotation = 8'd1;
        end
      end
      FUNC_CLEAR: begin
        foreach (digit[i]) digit[i] = '0;
        rotation = 8'd1;
        exhausted_flag = 1'b0;
      end
      default: ;
    endcase
    current_view(cand, len);
    r.candidate = cand;
    r.cand_length = len;
    r.exhausted = exhausted_flag;
    expected_results.push_back(r);
  endfunction

  function void check_result(bit [63:0] cand, bit [3:0] len, bit owned, bit exhausted);
    res_t want;
    if (expected_results.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: candidate %h length %0d owned %0b exhausted %0b",
                 cand, len, owned, exhausted);
      return;
    end
    want = expected_results.pop_front();
    if (cand !== want.candidate || len !== want.cand_length ||
        owned !== want.owned || exhausted !== want.exhausted) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: expected %h/%0d/%0b/%0b got %h/%0d/%0b/%0b",
                 want.candidate, want.cand_length, want.owned, want.exhausted,
                 cand, len, owned, exhausted);
    end
  endfunction
endclass

module testbench;
  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  localparam int QUIET_LIMIT = 2000;

  keyspace_tracker tracker = new;
  bit              slot_loaded [256];
  int              src_stall_pct = 35;
  int              sink_stall_pct = 48;
  int              quiet_cycles = 0;

  keyspace_candidate_generator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) tracker.write_register(cfg_idx_t'(cfg_index), cfg_data);
      if (s_tvalid && s_tready)
        tracker.note_request(func_t'(s_tuser), s_tdata[7:0], s_tdata[15:8]);
      if (m_tvalid && m_tready)
        tracker.check_result(m_tdata[63:0], m_tdata[67:64], m_tuser[0], m_tuser[1]);
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_request(func_t f, bit [7:0] idx, bit [7:0] chr);
    if (src_stall_pct != 0 && $urandom_range(99) < src_stall_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_stall_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= {chr, idx};
    do @(posedge clk); while (!s_tready);
    if (f == FUNC_LOAD) slot_loaded[idx] = 1'b1;
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait until every request has produced its result
  task automatic settle();
    s_tvalid <= 1'b0;
    // let the last accepted request reach the tracker first
    @(posedge clk);
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(bit [8:0] alen, bit [3:0] minl, bit [3:0] maxl,
                           bit [7:0] wcount, bit [7:0] wid, int items, bit clear_first);
    int unsigned pick;
    settle();
    write_reg(CFG_ALPHA_LEN, alen);
    write_reg(CFG_MIN_LEN, minl);
    write_reg(CFG_MAX_LEN, maxl);
    write_reg(CFG_WORKER_COUNT, wcount);
    write_reg(CFG_WORKER_ID, wid);
    cfg_valid <= 1'b0;
    @(posedge clk);
    // every slot an advance can show must hold a character first
    for (int k = 0; k < tracker.alphabet_in_use(); k++)
      if (!slot_loaded[k]) send_request(FUNC_LOAD, 8'(k), 8'($urandom_range(1, 255)));
    if (clear_first)
      send_request(FUNC_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 80)
        send_request(FUNC_ADVANCE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      else if (pick < 92)
        send_request(FUNC_LOAD, 8'($urandom_range(255)), 8'($urandom_range(1, 255)));
      else if (pick < 97)
        send_request(FUNC_NOP, 8'($urandom_range(255)), 8'($urandom_range(255)));
      else
        send_request(FUNC_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // register defaults: one-entry alphabet, so each advance lengthens the candidate until the row is full
    send_request(FUNC_NOP, 8'h00, 8'h00);
    send_request(FUNC_LOAD, 8'hFF, 8'h01);
    send_request(FUNC_LOAD, 8'h00, 8'hFF);
    repeat (9)
      send_request(FUNC_ADVANCE, 8'($urandom_range(255)), 8'($urandom_range(255)));
    send_request(FUNC_ADVANCE, 8'hFF, 8'hFF);
    send_request(FUNC_NOP, 8'hAA, 8'h55);
    send_request(FUNC_CLEAR, 8'h55, 8'hAA);
    // zero byte still counts as a nonempty position
    send_request(FUNC_LOAD, 8'h00, 8'h00);
    send_request(FUNC_ADVANCE, 8'h00, 8'h00);
    send_request(FUNC_ADVANCE, 8'h00, 8'h00);
    send_request(FUNC_CLEAR, 8'h00, 8'h00);
    send_request(FUNC_LOAD, 8'h00, 8'h5A);

    run_phase(9'd2, 4'd1, 4'd3, 8'd1, 8'd1, 100, 1'b1);
    run_phase(9'd3, 4'd2, 4'd4, 8'd3, 8'd2, 100, 1'b0);
    run_phase(9'd256, 4'd1, 4'd8, 8'd255, 8'd255, 100, 1'b0);

    src_stall_pct = 48;
    sink_stall_pct = 35;
    run_phase(9'd1, 4'd8, 4'd8, 8'd1, 8'd1, 60, 1'b1);
    // shorter row keeps the upper positions, worker id beyond the count
    run_phase(9'd5, 4'd3, 4'd2, 8'd4, 8'd7, 100, 1'b0);
    // smaller alphabet leaves stale indexes behind
    run_phase(9'd2, 4'd1, 4'd8, 8'd2, 8'd1, 100, 1'b0);

    src_stall_pct = 0;
    sink_stall_pct = 0;
    run_phase(9'd0, 4'd0, 4'd0, 8'd0, 8'd0, 60, 1'b1);
    run_phase(9'd511, 4'd15, 4'd15, 8'd200, 8'd3, 100, 1'b0);
    run_phase(9'd16, 4'd4, 4'd6, 8'd5, 8'd5, 150, 1'b1);
    run_phase(9'd7, 4'd1, 4'd1, 8'd1, 8'd1, 80, 1'b1);

    settle();
    repeat (8) @(posedge clk);
    if (tracker.failures == 0 && tracker.expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
